[rtl/bytecode_operand_rebaser_unit_assert.svh]
// Assertion helpers shared by the rebaser modules.
`ifndef BYTECODE_OPERAND_REBASER_UNIT_ASSERT_SVH
`define BYTECODE_OPERAND_REBASER_UNIT_ASSERT_SVH

// Same-cycle implication, idle during reset.
`define BOR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, idle during reset.
`define BOR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bor_pkg.sv]
package bor_pkg;

    // First opcode value that is not in the instruction set
    localparam logic [7:0] OPCODE_LIMIT = 8'd57;

    // Opcodes whose operands get special treatment
    localparam logic [5:0] OP_SYMBOL     = 6'd5;
    localparam logic [5:0] OP_STRING     = 6'd6;
    localparam logic [5:0] OP_JUMP       = 6'd26;
    localparam logic [5:0] OP_BRANCH     = 6'd27;
    localparam logic [5:0] OP_FN_CAPTURE = 6'd30;
    localparam logic [5:0] OP_LAUNCH     = 6'd34;
    localparam logic [5:0] OP_LAUNCH_LNK = 6'd35;
    localparam logic [5:0] OP_NAME_GET   = 6'd46;
    localparam logic [5:0] OP_LOOP       = 6'd49;
    localparam logic [5:0] OP_NAME_CALL  = 6'd56;

    // Configuration register indexes
    localparam logic CFG_CODE_BASE = 1'b0;
    localparam logic CFG_FN_BASE   = 1'b1;

    typedef enum logic [2:0] {
        PH_OPCODE  = 3'd0,
        PH_SKIP    = 3'd1,
        PH_OPERAND = 3'd2,
        PH_COUNT   = 3'd3,
        PH_STOPPED = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_OP    = 2'd1,
        ST_SYM_RANGE = 2'd2,
        ST_TRUNC     = 2'd3
    } t_status;

    // One group of 1..4 result bytes produced by one code byte
    typedef struct packed {
        logic        vld;
        logic [1:0]  last;       // index of last byte in word
        logic [31:0] word;       // bytes, little-endian order
        t_status     status;
        logic        stream_end;
        logic        sym_hit;    // word is replaced by the symbol map entry
    } t_emit;

    // Instruction length in bytes, zero for variable-length forms
    function automatic logic [3:0] len_of(input logic [5:0] op);
        logic [3:0] len;
        unique case (op) inside
            6'd3:                                   len = 4'd2;
            6'd4, 6'd45:                            len = 4'd9;
            OP_SYMBOL, 6'd7, 6'd8, OP_JUMP, OP_BRANCH, 6'd31, 6'd32,
            OP_LAUNCH, OP_LAUNCH_LNK, OP_NAME_GET, OP_LOOP, 6'd55:
                                                    len = 4'd5;
            OP_STRING, OP_FN_CAPTURE:               len = 4'd0;
            6'd54, OP_NAME_CALL:                    len = 4'd6;
            default:                                len = 4'd1;
        endcase
        return len;
    endfunction

    function automatic logic is_sym_op(input logic [5:0] op);
        return (op == OP_SYMBOL) || (op == OP_NAME_GET) || (op == OP_NAME_CALL);
    endfunction

    function automatic logic is_jump_op(input logic [5:0] op);
        return (op == OP_JUMP) || (op == OP_BRANCH) || (op == OP_LOOP);
    endfunction

    function automatic logic is_spawn_op(input logic [5:0] op);
        return (op == OP_LAUNCH) || (op == OP_LAUNCH_LNK);
    endfunction

endpackage

[rtl/bytecode_operand_rebaser_unit.sv]
// Channel   Direction  Handshake                   Transaction
// in        slave      i_in_valid / o_in_ready     one code byte or one symbol map write
// out       master     o_out_valid / i_out_ready   one result byte
// cfg       write      i_cfg_we                    one base register write
//
// An input transaction is taken every cycle while results flow freely.
// Results leave one byte per cycle from the output register while i_out_ready is
// high, so a completed operand (four bytes) stalls the input while its bytes
// drain; each group goes through s1, for the symbol map read, and then s2.
// Reset is synchronous, active low; it clears the scan state and base registers,
// not the symbol map. Output stalls back up through the two result stages.
module bytecode_operand_rebaser_unit import bor_pkg::*; #(
    parameter int SYMBOL_ENTRIES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [7:0]  i_code_byte,
    input  logic        i_final_byte,
    input  logic [9:0]  i_map_index,
    input  logic [30:0] i_map_value,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_stream_end,
    output logic [1:0]  o_status,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [30:0] i_cfg_data
);

    localparam int MAP_AW = (SYMBOL_ENTRIES > 1) ? $clog2(SYMBOL_ENTRIES) : 1;

    logic [30:0] r_code_base;
    logic [30:0] r_fn_base;

    logic              accept;
    t_emit             emit;
    logic [31:0]       map_idx_ext;
    logic              map_wr;
    logic              map_rd;
    logic [MAP_AW-1:0] map_addr;
    logic [30:0]       map_rdata;

    // base registers; the user must write them only while idle, the block does not check
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_base <= '0;
            r_fn_base   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CODE_BASE: r_code_base <= i_cfg_data;
                CFG_FN_BASE:   r_fn_base   <= i_cfg_data;
                default:       r_code_base <= r_code_base;
            endcase
        end
    end

    assign accept = i_in_valid && o_in_ready;

    bor_scan #(
        .SYMBOL_ENTRIES(SYMBOL_ENTRIES)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_action     (i_action),
        .i_code_byte  (i_code_byte),
        .i_final_byte (i_final_byte),
        .i_code_base  (r_code_base),
        .i_fn_base    (r_fn_base),
        .o_emit       (emit)
    );

    // Single-port symbol map: writes come from map transactions, reads from a
    // completed symbol operand; if both are raised, the write takes the port.
    assign map_idx_ext = 32'(i_map_index);
    assign map_wr      = accept && !i_action && (map_idx_ext < 32'(SYMBOL_ENTRIES));
    assign map_rd      = accept && emit.sym_hit;
    assign map_addr    = map_wr ? map_idx_ext[MAP_AW-1:0] : emit.word[MAP_AW-1:0];

    bor_ram #(
        .WIDTH  (31),
        .DEPTH  (SYMBOL_ENTRIES),
        .ADDR_W (MAP_AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_en    (map_wr || map_rd),
        .i_we    (map_wr),
        .i_addr  (map_addr),
        .i_wdata (i_map_value),
        .o_rdata (map_rdata)
    );

    bor_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept),
        .i_emit       (emit),
        .i_rdata      (map_rdata),
        .i_out_ready  (i_out_ready),
        .o_take       (o_in_ready),
        .o_out_valid  (o_out_valid),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_stream_end (o_stream_end),
        .o_status     (o_status)
    );

endmodule

[rtl/bor_ram.sv]
module bor_ram #(
    parameter int WIDTH  = 31,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bor_scan.sv]
`include "bytecode_operand_rebaser_unit_assert.svh"

module bor_scan import bor_pkg::*; #(
    parameter int SYMBOL_ENTRIES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic        i_action,
    input  logic [7:0]  i_code_byte,
    input  logic        i_final_byte,
    input  logic [30:0] i_code_base,
    input  logic [30:0] i_fn_base,
    output t_emit       o_emit
);

    t_phase      r_phase, n_phase;
    logic [5:0]  r_opcode, n_opcode;
    logic [31:0] r_buf, n_buf;
    logic [1:0]  r_cnt, n_cnt;
    logic [33:0] r_skip, n_skip;

    logic        code_act;
    logic [5:0]  op_in;
    logic        op_ok;
    logic [3:0]  byte_len;
    logic        direct;
    logic [31:0] w;
    logic        word_done;
    logic        sym_ok;
    logic [33:0] fin_skip;
    logic        fin_to_count;
    logic [31:0] jump_sum, fn_sum;

    assign code_act  = i_accept && i_action;
    assign op_in     = i_code_byte[5:0];
    assign op_ok     = i_code_byte < OPCODE_LIMIT;
    assign byte_len  = len_of(op_in);
    assign direct    = (byte_len == 4'd0) || is_sym_op(op_in) || is_jump_op(op_in)
                       || is_spawn_op(op_in);
    // operand word with the current byte merged at its lane
    assign w         = r_buf | (32'(i_code_byte) << {r_cnt, 3'b000});
    assign word_done = (r_cnt == 2'd3);
    assign sym_ok    = !w[31] && (w < 32'(SYMBOL_ENTRIES));
    assign jump_sum  = w + {1'b0, i_code_base};
    assign fn_sum    = w + {1'b0, i_fn_base};

    // skip length left after a completed operand
    always_comb begin
        fin_skip     = '0;
        fin_to_count = 1'b0;
        if (r_phase == PH_COUNT) begin
            fin_skip = w[31] ? 34'd0 : {w, 2'b00};
        end else if (is_sym_op(r_opcode)) begin
            fin_skip = (r_opcode == OP_NAME_CALL) ? 34'd1 : 34'd0;
        end else if (is_jump_op(r_opcode) || is_spawn_op(r_opcode)) begin
            fin_skip = '0;
        end else if (r_opcode == OP_FN_CAPTURE) begin
            fin_to_count = 1'b1;
        end else begin
            fin_skip = w[31] ? 34'd0 : 34'(w);
        end
    end

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_opcode = r_opcode;
        n_buf    = r_buf;
        n_cnt    = r_cnt;
        n_skip   = r_skip;
        if (code_act) begin
            unique case (r_phase)
                PH_OPCODE: begin
                    if (!op_ok) begin
                        n_phase = PH_STOPPED;
                    end else begin
                        n_opcode = op_in;
                        if (direct) begin
                            n_phase = PH_OPERAND;
                            n_buf   = '0;
                            n_cnt   = '0;
                        end else begin
                            n_skip  = 34'(byte_len) - 34'd1;
                            n_phase = (byte_len == 4'd1) ? PH_OPCODE : PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    if (r_skip <= 34'd1) begin
                        n_skip  = '0;
                        n_phase = PH_OPCODE;
                    end else begin
                        n_skip = r_skip - 34'd1;
                    end
                end
                PH_OPERAND, PH_COUNT: begin
                    n_buf = w;
                    if (word_done) begin
                        n_buf  = '0;
                        n_cnt  = '0;
                        n_skip = fin_skip;
                        if (fin_to_count) begin
                            n_phase = PH_COUNT;
                        end else begin
                            n_phase = (fin_skip != '0) ? PH_SKIP : PH_OPCODE;
                        end
                    end else if (!i_final_byte) begin
                        n_cnt = r_cnt + 2'd1;
                    end
                end
                PH_STOPPED: begin
                    n_phase = PH_STOPPED;
                end
                default: begin
                    n_phase = PH_OPCODE;
                end
            endcase
            if (i_final_byte) begin
                n_phase  = PH_OPCODE;
                n_opcode = '0;
                n_buf    = '0;
                n_cnt    = '0;
                n_skip   = '0;
            end
        end
    end

    // result group for this byte
    always_comb begin
        o_emit            = '0;
        o_emit.stream_end = i_final_byte;
        o_emit.status     = ST_OK;
        o_emit.word       = 32'(i_code_byte);
        unique case (r_phase)
            PH_OPCODE: begin
                o_emit.vld    = code_act;
                o_emit.status = op_ok ? ST_OK : ST_BAD_OP;
            end
            PH_SKIP: begin
                o_emit.vld = code_act;
            end
            PH_OPERAND, PH_COUNT: begin
                o_emit.word = w;
                if (word_done) begin
                    o_emit.vld  = code_act;
                    o_emit.last = 2'd3;
                    if (r_phase == PH_COUNT) begin
                        o_emit.word = w;
                    end else if (is_sym_op(r_opcode)) begin
                        o_emit.status  = sym_ok ? ST_OK : ST_SYM_RANGE;
                        o_emit.sym_hit = sym_ok;
                    end else if (is_jump_op(r_opcode)) begin
                        o_emit.word = jump_sum;
                    end else if (is_spawn_op(r_opcode) || r_opcode == OP_FN_CAPTURE) begin
                        o_emit.word = fn_sum;
                    end
                end else if (i_final_byte) begin
                    // section ends mid-operand: flush held bytes as they came
                    o_emit.vld    = code_act;
                    o_emit.last   = r_cnt;
                    o_emit.status = ST_TRUNC;
                end
            end
            PH_STOPPED: begin
                o_emit.vld    = code_act;
                o_emit.status = ST_BAD_OP;
            end
            default: begin
                o_emit.vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_OPCODE;
            r_opcode <= '0;
            r_buf    <= '0;
            r_cnt    <= '0;
            r_skip   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_buf    <= n_buf;
            r_cnt    <= n_cnt;
            r_skip   <= n_skip;
        end
    end

    `BOR_ASSERT_IMPLY(a_skip_nonzero, i_clk, i_rst_n, r_phase == PH_SKIP,
                      r_skip != '0, "skip phase with zero count")
    `BOR_ASSERT_IMPLY(a_cnt_phase, i_clk, i_rst_n, r_cnt != 2'd0,
                      r_phase == PH_OPERAND || r_phase == PH_COUNT,
                      "operand bytes held outside operand phase")
    `BOR_ASSERT_NEXT(a_final_clears, i_clk, i_rst_n, code_act && i_final_byte,
                     r_phase == PH_OPCODE && r_cnt == 2'd0 && r_buf == '0,
                     "scan state not cleared after section end")

endmodule

[rtl/bor_out.sv]
`include "bytecode_operand_rebaser_unit_assert.svh"

module bor_out import bor_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_emit       i_emit,
    input  logic [30:0] i_rdata,
    input  logic        i_out_ready,
    output logic        o_take,
    output logic        o_out_valid,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_stream_end,
    output logic [1:0]  o_status
);

    // s1 holds a group alongside its symbol map read; s2 sends one byte per cycle while i_out_ready is high
    t_emit       r_s1;
    logic        r_s1_valid;
    logic [31:0] r_s2_word;
    logic [1:0]  r_s2_last;
    logic [1:0]  r_s2_idx;
    t_status     r_s2_status;
    logic        r_s2_end;
    logic        r_s2_valid;

    logic s2_done;
    logic s2_free;
    logic s1_move;

    assign s2_done = r_s2_valid && i_out_ready && (r_s2_idx == r_s2_last);
    assign s2_free = !r_s2_valid || s2_done;
    assign s1_move = r_s1_valid && s2_free;
    assign o_take  = !r_s1_valid || s1_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s2_idx   <= '0;
        end else begin
            if (i_load && i_emit.vld) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_s2_valid <= 1'b1;
                r_s2_idx   <= '0;
            end else if (s2_done) begin
                r_s2_valid <= 1'b0;
            end else if (r_s2_valid && i_out_ready) begin
                r_s2_idx <= r_s2_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_emit.vld) begin
            r_s1 <= i_emit;
        end
        if (s1_move) begin
            r_s2_word   <= r_s1.sym_hit ? {1'b0, i_rdata} : r_s1.word;
            r_s2_last   <= r_s1.last;
            r_s2_status <= r_s1.status;
            r_s2_end    <= r_s1.stream_end;
        end
    end

    assign o_out_valid  = r_s2_valid;
    assign o_out_byte   = 8'(r_s2_word >> {r_s2_idx, 3'b000});
    assign o_run_last   = (r_s2_idx == r_s2_last);
    assign o_stream_end = r_s2_end;
    assign o_status     = r_s2_status;

    `BOR_ASSERT_IMPLY(a_idx_range, i_clk, i_rst_n, r_s2_valid, r_s2_idx <= r_s2_last, "byte index past end of group")
    `BOR_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !s2_free, r_s1_valid && $stable(r_s1.word), "stalled group lost or changed")

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
    import bor_pkg::*;

    localparam int SYM_DEPTH    = 1024;
    localparam int DRAIN_CYCLES = 8;      // output pipe is two stages deep, map writes are silent
    localparam int RUN_LIMIT_NS = 2_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_action;
    logic [7:0]  i_code_byte;
    logic        i_final_byte;
    logic [9:0]  i_map_index;
    logic [30:0] i_map_value;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_out_byte;
    logic        o_run_last;
    logic        o_stream_end;
    logic [1:0]  o_status;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [30:0] i_cfg_data;

    bytecode_operand_rebaser_unit #(
        .SYMBOL_ENTRIES(SYM_DEPTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_code_byte (i_code_byte),
        .i_final_byte(i_final_byte),
        .i_map_index (i_map_index),
        .i_map_value (i_map_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .o_stream_end(o_stream_end),
        .o_status    (o_status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // One expected output transaction
    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       stream_end;
        t_status    status;
    } t_rebased;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SLOW, RX_CHOPPY} t_rx_mode;

    // Instruction length per opcode; zero marks the variable-length forms
    bit [3:0] instr_len_tbl [57] = '{
        1, 1, 1, 2, 9, 5, 0, 5, 5, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
        1, 1, 1, 1, 1, 1, 5, 5, 1, 1, 0, 5, 5, 1, 5, 5, 1, 1, 1, 1,
        1, 1, 1, 1, 1, 9, 5, 1, 1, 5, 1, 1, 1, 1, 6, 5, 6
    };

    // Opcodes carrying a 32-bit operand word right after the opcode
    logic [5:0] operand_ops [10] = '{
        OP_SYMBOL, OP_STRING, OP_JUMP, OP_BRANCH, OP_FN_CAPTURE,
        OP_LAUNCH, OP_LAUNCH_LNK, OP_NAME_GET, OP_LOOP, OP_NAME_CALL
    };

    // Scan state mirror
    t_phase      scan_ph;
    logic [5:0]  scan_op;
    logic [31:0] opnd_word;
    logic [1:0]  opnd_cnt;
    logic [33:0] skip_left;
    logic [30:0] sym_tab [SYM_DEPTH];
    bit          sym_set [SYM_DEPTH];
    logic [30:0] code_base_m;
    logic [30:0] fn_base_m;

    t_rebased    step_q[$];      // results of the code byte being predicted
    t_rebased    rebased_q[$];   // results still owed by the block
    logic [7:0]  prog_q[$];      // code bytes of the section being built

    int burst_left;
    int fail_cnt;
    int code_cnt;
    int map_cnt;
    int results_checked;
    int base_settings;
    int status_seen [4];

    function automatic bit reads_symbol(input logic [5:0] op);
        return op == OP_SYMBOL || op == OP_NAME_GET || op == OP_NAME_CALL;
    endfunction

    function automatic bit adds_code_base(input logic [5:0] op);
        return op == OP_JUMP || op == OP_BRANCH || op == OP_LOOP;
    endfunction

    function automatic bit adds_fn_base(input logic [5:0] op);
        return op == OP_LAUNCH || op == OP_LAUNCH_LNK;
    endfunction

    function automatic void emit_byte(input logic [7:0] b, input t_status st);
        t_rebased r;
        r.data       = b;
        r.run_last   = 1'b0;
        r.stream_end = 1'b0;
        r.status     = st;
        step_q.push_back(r);
    endfunction

    function automatic void emit_word(input logic [31:0] w, input t_status st);
        for (int i = 0; i < 4; i++)
            emit_byte(w[8*i +: 8], st);
    endfunction

    function automatic void start_skip(input logic [33:0] n);
        skip_left = n;
        scan_ph   = (n != 34'd0) ? PH_SKIP : PH_OPCODE;
    endfunction

    function automatic void clear_scan();
        scan_ph   = PH_OPCODE;
        scan_op   = '0;
        opnd_word = '0;
        opnd_cnt  = '0;
        skip_left = '0;
    endfunction

    // Fourth operand byte arrived: rewrite the word and pick what follows it
    function automatic void close_operand();
        logic [31:0] w;
        w         = opnd_word;
        opnd_word = '0;
        opnd_cnt  = '0;
        if (scan_ph == PH_COUNT) begin
            // closure free-variable count, four bytes per variable follow
            emit_word(w, ST_OK);
            start_skip(w[31] ? 34'd0 : {w, 2'b00});
        end else if (reads_symbol(scan_op)) begin
            if (!w[31] && w < 32'(SYM_DEPTH))
                emit_word({1'b0, sym_tab[w[9:0]]}, ST_OK);
            else
                emit_word(w, ST_SYM_RANGE);
            start_skip(scan_op == OP_NAME_CALL ? 34'd1 : 34'd0);
        end else if (adds_code_base(scan_op)) begin
            emit_word(w + {1'b0, code_base_m}, ST_OK);
            start_skip(34'd0);
        end else if (adds_fn_base(scan_op)) begin
            emit_word(w + {1'b0, fn_base_m}, ST_OK);
            start_skip(34'd0);
        end else if (scan_op == OP_FN_CAPTURE) begin
            emit_word(w + {1'b0, fn_base_m}, ST_OK);
            scan_ph = PH_COUNT;
        end else begin
            // string length word, negative means empty body
            emit_word(w, ST_OK);
            start_skip(w[31] ? 34'd0 : {2'b00, w});
        end
    endfunction

    // Works out the output bytes owed for one accepted input transaction
    function automatic void predict_rebase(input bit act, input logic [7:0] b, input bit fin,
                                           input logic [9:0] idx, input logic [30:0] val);
        logic [1:0] cnt;
        t_rebased   r;
        step_q.delete();
        if (!act) begin
            // every 10-bit index lies inside the table
            sym_tab[idx] = val;
            sym_set[idx] = 1'b1;
        end else begin
            case (scan_ph)
                PH_OPCODE: begin
                    if (b >= OPCODE_LIMIT) begin
                        scan_ph = PH_STOPPED;
                        emit_byte(b, ST_BAD_OP);
                    end else begin
                        scan_op = b[5:0];
                        emit_byte(b, ST_OK);
                        if (instr_len_tbl[b] == 4'd0 || reads_symbol(b[5:0]) ||
                            adds_code_base(b[5:0]) || adds_fn_base(b[5:0])) begin
                            scan_ph   = PH_OPERAND;
                            opnd_word = '0;
                            opnd_cnt  = '0;
                        end else begin
                            start_skip(34'(instr_len_tbl[b]) - 34'd1);
                        end
                    end
                end
                PH_SKIP: begin
                    emit_byte(b, ST_OK);
                    if (skip_left != 34'd0)
                        skip_left = skip_left - 34'd1;
                    if (skip_left == 34'd0)
                        scan_ph = PH_OPCODE;
                end
                PH_OPERAND, PH_COUNT: begin
                    cnt       = opnd_cnt;
                    opnd_word = opnd_word | (32'(b) << (8 * cnt));
                    if (cnt == 2'd3) begin
                        close_operand();
                    end else if (fin) begin
                        // section ends inside the operand: flush what is held
                        for (int i = 0; i <= int'(cnt); i++)
                            emit_byte(opnd_word[8*i +: 8], ST_TRUNC);
                    end else begin
                        opnd_cnt = cnt + 2'd1;
                    end
                end
                default: emit_byte(b, ST_BAD_OP);
            endcase
            for (int k = 0; k < step_q.size(); k++) begin
                r            = step_q[k];
                r.run_last   = (k == step_q.size() - 1);
                r.stream_end = fin;
                rebased_q.push_back(r);
            end
            if (fin)
                clear_scan();
        end
    endfunction

    // Sends one input transaction; the sender may idle between bursts of random length
    task automatic send_txn(input bit act, input logic [7:0] cbyte, input bit fin,
                            input logic [9:0] idx, input logic [30:0] val);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : int'($urandom_range(1, 12));
            gap        = $urandom_range(0, 5);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_code_byte  <= cbyte;
        i_final_byte <= fin;
        i_map_index  <= idx;
        i_map_value  <= val;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        predict_rebase(act, cbyte, fin, idx, val);
        if (act)
            code_cnt++;
        else
            map_cnt++;
    endtask

    // A code byte that would complete an in-table symbol index of an entry never
    // loaded gets a map write for that entry in front of it.
    task automatic send_code(input logic [7:0] cbyte, input bit fin);
        logic [31:0] w_next;
        w_next = {cbyte, opnd_word[23:0]};
        if (scan_ph == PH_OPERAND && reads_symbol(scan_op) && opnd_cnt == 2'd3 &&
            !w_next[31] && w_next < 32'(SYM_DEPTH) && !sym_set[w_next[9:0]])
            send_txn(1'b0, 8'($urandom()), 1'($urandom()), w_next[9:0], 31'($urandom()));
        send_txn(1'b1, cbyte, fin, 10'($urandom()), 31'($urandom()));
    endtask

    task automatic send_queued(input int stop_at, input bit mix_maps);
        for (int k = 0; k <= stop_at; k++) begin
            if (mix_maps && $urandom_range(0, 15) == 0)
                send_txn(1'b0, 8'($urandom()), 1'($urandom()), 10'($urandom()),
                         31'($urandom()));
            send_code(prog_q[k], k == stop_at);
        end
    endtask

    // Both base registers, back to back, only while the block is idle
    task automatic load_bases(input logic [30:0] cb, input logic [30:0] fb);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_CODE_BASE;
        i_cfg_data  <= cb;
        @(posedge i_clk);
        code_base_m = cb;
        i_cfg_index <= CFG_FN_BASE;
        i_cfg_data  <= fb;
        @(posedge i_clk);
        fn_base_m = fb;
        i_cfg_we <= 1'b0;
        base_settings++;
    endtask

    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (rebased_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] any_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return 32'h0000_0000;
        else if (pick < 30)
            return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    // Mostly a small pool of table entries, plus the top entry and both kinds of miss
    function automatic logic [31:0] symbol_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return $urandom_range(0, 15);
        else if (pick < 75)
            return 32'(SYM_DEPTH - 1);
        else if (pick < 87)
            return $urandom_range(SYM_DEPTH, 32'h7FFF_FFFF);
        return 32'h8000_0000 | $urandom();
    endfunction

    function automatic logic [31:0] length_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return $urandom_range(0, 5);
        else if (pick < 80)
            return 32'h8000_0000 | $urandom();
        return $urandom_range(6, 40);
    endfunction

    function automatic void push_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            prog_q.push_back(w[8*i +: 8]);
    endfunction

    // Appends one instruction with random content; long bodies are cut short,
    // which leaves the scan out of step with the byte stream on purpose
    function automatic void build_instr();
        logic [7:0]  op;
        logic [31:0] w;
        int          body;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            op = {2'b00, operand_ops[$urandom_range(0, 9)]};
        else if (pick < 93)
            op = 8'($urandom_range(0, 56));
        else
            op = 8'($urandom_range(57, 255));
        prog_q.push_back(op);
        if (op < OPCODE_LIMIT) begin
            if (reads_symbol(op[5:0])) begin
                push_word(symbol_word());
                if (op[5:0] == OP_NAME_CALL)
                    prog_q.push_back(8'($urandom()));
            end else if (adds_code_base(op[5:0]) || adds_fn_base(op[5:0])) begin
                push_word(any_word());
            end else if (op[5:0] == OP_FN_CAPTURE || op[5:0] == OP_STRING) begin
                if (op[5:0] == OP_FN_CAPTURE)
                    push_word(any_word());
                w = length_word();
                push_word(w);
                body = w[31] ? 0 : int'(w[15:0]) * ((op[5:0] == OP_FN_CAPTURE) ? 4 : 1);
                if (body > 12)
                    body = 12;
                repeat (body) prog_q.push_back(8'($urandom()));
            end else begin
                repeat (int'(instr_len_tbl[op]) - 1) prog_q.push_back(8'($urandom()));
            end
        end
    endfunction

    // One code section of 1..5 instructions, now and then cut off at a random byte
    task automatic send_program();
        int n_instr;
        int stop_at;
        prog_q.delete();
        n_instr = $urandom_range(1, 5);
        repeat (n_instr) build_instr();
        stop_at = prog_q.size() - 1;
        if ($urandom_range(0, 3) == 0)
            stop_at = $urandom_range(0, stop_at);
        send_queued(stop_at, 1'b1);
    endtask

    // Both bases at their top value: table top entry, missed index with a
    // trailing byte, jump target wrap, stop on the first bad opcode, an operand
    // cut short, and a closure id completed by the last byte of its section.
    task automatic test_directed_edges();
        load_bases(31'h7FFF_FFFF, 31'h7FFF_FFFF);
        // final_byte has no meaning on a map write
        send_txn(1'b0, 8'h00, 1'b1, 10'(SYM_DEPTH - 1), 31'h7FFF_FFFF);
        prog_q = '{8'(OP_NAME_GET), 8'hFF, 8'h03, 8'h00, 8'h00,
                   8'(OP_JUMP), 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                   8'(OP_NAME_CALL), 8'h00, 8'h04, 8'h00, 8'h00, 8'hAA,
                   OPCODE_LIMIT, 8'hFF};
        send_queued(prog_q.size() - 1, 1'b0);
        prog_q = '{8'(OP_FN_CAPTURE), 8'h01, 8'h02};
        send_queued(prog_q.size() - 1, 1'b0);
        prog_q = '{8'(OP_FN_CAPTURE), 8'h00, 8'h00, 8'h00, 8'h80};
        send_queued(prog_q.size() - 1, 1'b0);
        wait_quiet();
    endtask

    task automatic test_random_programs(input logic [30:0] cb, input logic [30:0] fb,
                                        input int budget);
        int start;
        load_bases(cb, fb);
        start = code_cnt + map_cnt;
        while (code_cnt + map_cnt - start < budget)
            send_program();
        wait_quiet();
    endtask

    // Unstructured bytes and map writes, sections ending at random
    task automatic test_byte_noise(input int count);
        logic [7:0] b;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                send_txn(1'b0, 8'($urandom()), 1'($urandom()), 10'($urandom()),
                         31'($urandom()));
            end else begin
                b = $urandom_range(0, 1) ? 8'($urandom_range(0, 56)) : 8'($urandom());
                send_code(b, k == count - 1 || $urandom_range(0, 7) == 0);
            end
        end
        wait_quiet();
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: switches between four stall patterns chosen at random
    initial begin : out_stall_pattern
        t_rx_mode mode;
        i_out_ready <= 1'b0;
        forever begin
            mode = t_rx_mode'($urandom_range(0, 3));
            repeat ($urandom_range(16, 80)) begin
                @(posedge i_clk);
                case (mode)
                    RX_OPEN:   i_out_ready <= 1'b1;
                    RX_COIN:   i_out_ready <= 1'($urandom());
                    RX_SLOW:   i_out_ready <= ($urandom_range(0, 3) == 0);
                    default:   i_out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Each output transaction is matched against the oldest owed byte
    always @(posedge i_clk) begin : check_results
        t_rebased want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_checked++;
            status_seen[o_status]++;
            if (rebased_q.size() == 0) begin
                $error("result byte %02h with status %0d arrived with nothing owed",
                       o_out_byte, o_status);
                fail_cnt++;
            end else begin
                want = rebased_q.pop_front();
                if (o_out_byte !== want.data) begin
                    $error("out_byte: expected %02h, got %02h", want.data, o_out_byte);
                    fail_cnt++;
                end
                if (o_run_last !== want.run_last) begin
                    $error("run_last: expected %0b, got %0b", want.run_last, o_run_last);
                    fail_cnt++;
                end
                if (o_stream_end !== want.stream_end) begin
                    $error("stream_end: expected %0b, got %0b", want.stream_end, o_stream_end);
                    fail_cnt++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("[bytecode_operand_rebaser_unit] ERROR");
        $finish;
    end

    initial begin : main_seq
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_action     <= 1'b0;
        i_code_byte  <= '0;
        i_final_byte <= 1'b0;
        i_map_index  <= '0;
        i_map_value  <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= CFG_CODE_BASE;
        i_cfg_data   <= '0;
        clear_scan();
        code_base_m = '0;
        fn_base_m   = '0;
        foreach (sym_set[i])
            sym_set[i] = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_random_programs(31'd0, 31'd0, 16);
        test_random_programs(31'($urandom()), 31'($urandom()), 16);
        test_random_programs(31'd0, 31'h7FFF_FFFF, 12);
        test_byte_noise(18);

        if (rebased_q.size() != 0) begin
            $error("%0d expected result bytes never arrived", rebased_q.size());
            fail_cnt++;
        end
        $display("Covered %0d code bytes and %0d symbol map writes under %0d base settings.",
                 code_cnt, map_cnt, base_settings);
        $display("Checked %0d result bytes: %0d ok, %0d stopped, %0d out of table, %0d cut.",
                 results_checked, status_seen[ST_OK], status_seen[ST_BAD_OP],
                 status_seen[ST_SYM_RANGE], status_seen[ST_TRUNC]);
        if (fail_cnt == 0)
            $display("[bytecode_operand_rebaser_unit] OK");
        else
            $display("[bytecode_operand_rebaser_unit] ERROR");
        $finish;
    end

endmodule

[bytecode_operand_rebaser_unit.f]
+incdir+rtl
rtl/bor_pkg.sv
rtl/bor_ram.sv
rtl/bor_scan.sv
rtl/bor_out.sv
rtl/bytecode_operand_rebaser_unit.sv
verif/tb.sv
